// ===== sv/sorted_timeout_queue_assert.svh =====
// Assertion macros for the sorted timeout queue checker.
// Include-only header; no dependencies.
`ifndef SORTED_TIMEOUT_QUEUE_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset.
`define STQ_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("sorted_timeout_queue assertion failed");

// Same, on the usual clk / arst_n names.
`define STQ_ASSERT(lbl, prop) `STQ_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

// ===== sv/stq_pkg.sv =====
// Shared types, codes and helpers for the sorted timeout queue.
// No dependencies.
package stq_pkg;

	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int ID_W      = 8;
	localparam int TICK_W    = 32;
	localparam int S_TDATA_W = 72;  // id + delay + now, padded to bytes
	localparam int M_TDATA_W = 40;  // id + sleep

	localparam int MAX_RESULTS = 16;
	localparam int NR_W        = $clog2(MAX_RESULTS + 1);

	localparam logic [TICK_W-1:0] HALF_RANGE = 32'h7fff_ffff;

	localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EXPIRED = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NONE    = 2'd3;

	typedef logic [TICK_W-1:0] tick_t;

	// a strictly earlier than b, modulo 2^32
	function automatic logic stq_before(input tick_t a, input tick_t b);
		tick_t d;
		d = a - b;
		return d > HALF_RANGE;
	endfunction

endpackage

// ===== sv/sorted_timeout_queue.sv =====
// Sorted timeout queue: deadline-ordered timer table in a ring memory.
// Depends on stq_pkg.
// Requests enter on s_axis_* (tuser = opcode, tdata = id, delay, now) and
// results leave on m_axis_* (tuser = status, tdata = id, sleep, tlast on the
// final result of a request). One request is worked at a time; s_axis_tready
// is high only while the sequencer is idle.
// Entries sit in a ring memory (deadline + id) addressed from a head pointer,
// with registered read data. Every walk streams one entry per cycle through
// the single read port, with the write port trailing the read port.
// Steps per request:
//   arm    : id scan + close-up, then slot scan + open-up and the insert;
//            an arm dropped on a full table skips slot scan and insert.
//   cancel : id scan + close-up, then the result.
//   check  : head read, then pop, per expired entry, then the result.
//   query  : head read, then the result; only the result on an empty table.
// Popping only moves the head pointer, so check never shifts the memory.
// Results go through a one-deep output register; a new request can be taken
// while the last result of the previous one still waits. When the receiver
// stalls, the sequencer holds in place until the output register frees.
// Reset clears count, head and any pending result; memory contents stay.
module sorted_timeout_queue
	import stq_pkg::*;
#(
	parameter int MAX_TIMERS = 16,
	parameter int ID_BITS    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [7:0] timer_id, [39:8] delay_ticks, [71:40] now_ticks
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] opcode
	input  logic [OP_W-1:0]      s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [7:0] expired_id, [39:8] sleep_ticks
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// [1:0] status
	output logic [STAT_W-1:0]    m_axis_tuser,
	output logic                 m_axis_tlast
);

	localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int IW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TIMERS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIND   = 4'd1;   // look for matching id
	localparam logic [3:0] S_SHDN   = 4'd2;   // close the gap
	localparam logic [3:0] S_ARMCHK = 4'd3;
	localparam logic [3:0] S_POS    = 4'd4;   // find insert slot
	localparam logic [3:0] S_SHUP   = 4'd5;   // open a gap
	localparam logic [3:0] S_INS    = 4'd6;
	localparam logic [3:0] S_CHKRD  = 4'd7;
	localparam logic [3:0] S_CHKEV  = 4'd8;
	localparam logic [3:0] S_QRYRD  = 4'd9;
	localparam logic [3:0] S_QRYEV  = 4'd10;
	localparam logic [3:0] S_RESP   = 4'd11;

	// logical index -> physical ring address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
	                                       input logic [CW-1:0] li);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(li);
		if (s >= (CW+1)'(MAX_TIMERS))
			s = s - (CW+1)'(MAX_TIMERS);
		return AW'(s);
	endfunction

	// table memory
	tick_t         mem_dl [MAX_TIMERS];
	logic [IW-1:0] mem_id [MAX_TIMERS];
	tick_t         rd_dl_q;
	logic [IW-1:0] rd_id_q;

	logic          rd_en, wr_en;
	logic [CW-1:0] rd_li, wr_li;
	tick_t         wr_dl;
	logic [IW-1:0] wr_id;

	// control state
	logic [3:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          v_s1, v_d;
	logic [CW-1:0] lidx_s1, lidx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [NR_W-1:0] n_q, n_d;
	logic          pend_v_q, pend_v_d;
	logic [IW-1:0] pend_id_q, pend_id_d;

	// request payload
	logic [OP_W-1:0] op_q, op_d;
	logic [IW-1:0]   id_q, id_d;
	tick_t           dl_q, dl_d;
	tick_t           now_q, now_d;
	logic [STAT_W-1:0] res_status_q, res_status_d;
	tick_t           res_sleep_q, res_sleep_d;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [ID_W-1:0]   out_id_q;
	tick_t             out_sleep_q;
	logic              out_last_q;

	logic              out_free, out_load, out_last;
	logic [STAT_W-1:0] out_status;
	logic [ID_W-1:0]   out_id;
	tick_t             out_sleep;

	logic match, last_rd, due;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_sleep_q, out_id_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	assign match   = v_s1 && (rd_id_q == id_q);
	assign last_rd = v_s1 && (lidx_s1 == count_q - CW'(1));
	assign due     = !stq_before(now_q, rd_dl_q);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		head_d       = head_q;
		idx_d        = idx_q;
		v_d          = v_s1;
		lidx_d       = lidx_s1;
		pos_d        = pos_q;
		n_d          = n_q;
		pend_v_d     = pend_v_q;
		pend_id_d    = pend_id_q;
		op_d         = op_q;
		id_d         = id_q;
		dl_d         = dl_q;
		now_d        = now_q;
		res_status_d = res_status_q;
		res_sleep_d  = res_sleep_q;
		rd_en        = 1'b0;
		rd_li        = '0;
		wr_en        = 1'b0;
		wr_li        = '0;
		wr_dl        = dl_q;
		wr_id        = id_q;
		out_load     = 1'b0;
		out_status   = STAT_DONE;
		out_id       = '0;
		out_sleep    = '0;
		out_last     = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					op_d         = s_axis_tuser;
					id_d         = s_axis_tdata[IW-1:0];
					now_d        = s_axis_tdata[71:40];
					dl_d         = s_axis_tdata[71:40] + s_axis_tdata[39:8];
					idx_d        = '0;
					v_d          = 1'b0;
					n_d          = '0;
					pend_v_d     = 1'b0;
					res_status_d = STAT_DONE;
					res_sleep_d  = '0;
					unique case (s_axis_tuser)
						OP_ARM, OP_CANCEL: state_d = S_FIND;
						OP_CHECK:          state_d = S_CHKRD;
						OP_QUERY: begin
							if (count_q == '0) begin
								res_sleep_d = '1;
								state_d     = S_RESP;
							end else begin
								state_d = S_QRYRD;
							end
						end
					endcase
				end
			end
			S_FIND: begin
				priority if (count_q == '0 || (last_rd && !match)) begin
					v_d     = 1'b0;
					state_d = (op_q == OP_ARM) ? S_ARMCHK : S_RESP;
				end else if (match) begin
					v_d     = 1'b0;
					idx_d   = lidx_s1 + CW'(1);
					state_d = S_SHDN;
				end else if (idx_q < count_q) begin
					rd_en  = 1'b1;
					rd_li  = idx_q;
					lidx_d = idx_q;
					idx_d  = idx_q + CW'(1);
					v_d    = 1'b1;
				end else begin
					v_d = 1'b0;
				end
			end
			S_SHDN: begin
				// entry i+1 moves down to i
				if (v_s1) begin
					wr_en = 1'b1;
					wr_li = lidx_s1 - CW'(1);
					wr_dl = rd_dl_q;
					wr_id = rd_id_q;
				end
				if (idx_q < count_q) begin
					rd_en  = 1'b1;
					rd_li  = idx_q;
					lidx_d = idx_q;
					idx_d  = idx_q + CW'(1);
					v_d    = 1'b1;
				end else begin
					v_d = 1'b0;
				end
				if (!v_s1 && idx_q >= count_q) begin
					count_d = count_q - CW'(1);
					state_d = (op_q == OP_ARM) ? S_ARMCHK : S_RESP;
				end
			end
			S_ARMCHK: begin
				priority if (count_q >= CNT_MAX) begin
					res_status_d = STAT_FULL;
					state_d      = S_RESP;
				end else if (count_q == '0) begin
					pos_d   = '0;
					state_d = S_INS;
				end else begin
					idx_d   = '0;
					v_d     = 1'b0;
					state_d = S_POS;
				end
			end
			S_POS: begin
				// insert ahead of the first strictly later deadline
				priority if (v_s1 && stq_before(dl_q, rd_dl_q)) begin
					pos_d   = lidx_s1;
					v_d     = 1'b0;
					idx_d   = count_q;
					state_d = S_SHUP;
				end else if (last_rd) begin
					pos_d   = count_q;
					v_d     = 1'b0;
					idx_d   = count_q;
					state_d = S_SHUP;
				end else if (idx_q < count_q) begin
					rd_en  = 1'b1;
					rd_li  = idx_q;
					lidx_d = idx_q;
					idx_d  = idx_q + CW'(1);
					v_d    = 1'b1;
				end else begin
					v_d = 1'b0;
				end
			end
			S_SHUP: begin
				// entry i-1 moves up to i, walking down from the tail
				if (v_s1) begin
					wr_en = 1'b1;
					wr_li = lidx_s1 + CW'(1);
					wr_dl = rd_dl_q;
					wr_id = rd_id_q;
				end
				if (idx_q > pos_q) begin
					rd_en  = 1'b1;
					rd_li  = idx_q - CW'(1);
					lidx_d = idx_q - CW'(1);
					idx_d  = idx_q - CW'(1);
					v_d    = 1'b1;
				end else begin
					v_d = 1'b0;
				end
				if (!v_s1 && idx_q <= pos_q)
					state_d = S_INS;
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_li   = pos_q;
				count_d = count_q + CW'(1);
				state_d = S_RESP;
			end
			S_CHKRD: begin
				if (n_q == NR_W'(MAX_RESULTS) || count_q == '0) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_status = pend_v_q ? STAT_EXPIRED : STAT_NONE;
						out_id     = pend_v_q ? ID_W'(pend_id_q) : '0;
						state_d    = S_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_li   = '0;
					state_d = S_CHKEV;
				end
			end
			S_CHKEV: begin
				// one expiry is held back until we know whether it is the last
				if (due) begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_load   = 1'b1;
							out_status = STAT_EXPIRED;
							out_id     = ID_W'(pend_id_q);
							out_last   = 1'b0;
						end
						pend_v_d  = 1'b1;
						pend_id_d = rd_id_q;
						head_d    = (head_q == AW'(MAX_TIMERS - 1)) ? '0
						            : head_q + AW'(1);
						count_d   = count_q - CW'(1);
						n_d       = n_q + NR_W'(1);
						state_d   = S_CHKRD;
					end
				end else if (out_free) begin
					out_load   = 1'b1;
					out_status = pend_v_q ? STAT_EXPIRED : STAT_NONE;
					out_id     = pend_v_q ? ID_W'(pend_id_q) : '0;
					state_d    = S_IDLE;
				end
			end
			S_QRYRD: begin
				rd_en   = 1'b1;
				rd_li   = '0;
				state_d = S_QRYEV;
			end
			S_QRYEV: begin
				res_sleep_d = stq_before(rd_dl_q, now_q) ? '0 : rd_dl_q - now_q;
				state_d     = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = res_status_q;
					out_sleep  = res_sleep_q;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// table memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_dl[phys(head_q, wr_li)] <= wr_dl;
			mem_id[phys(head_q, wr_li)] <= wr_id;
		end
		if (rd_en) begin
			rd_dl_q <= mem_dl[phys(head_q, rd_li)];
			rd_id_q <= mem_id[phys(head_q, rd_li)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			v_s1        <= 1'b0;
			pend_v_q    <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			head_q   <= head_d;
			v_s1     <= v_d;
			pend_v_q <= pend_v_d;
			idx_q    <= idx_d;
			n_q      <= n_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		lidx_s1      <= lidx_d;
		pos_q        <= pos_d;
		pend_id_q    <= pend_id_d;
		op_q         <= op_d;
		id_q         <= id_d;
		dl_q         <= dl_d;
		now_q        <= now_d;
		res_status_q <= res_status_d;
		res_sleep_q  <= res_sleep_d;
		if (out_load) begin
			out_status_q <= out_status;
			out_id_q     <= out_id;
			out_sleep_q  <= out_sleep;
			out_last_q   <= out_last;
		end
	end

endmodule

// ===== sv/stq_checker.sv =====
// Port-level checker for sorted_timeout_queue, bound to the top level.
// Depends on stq_pkg and sorted_timeout_queue_assert.svh.
`include "sorted_timeout_queue_assert.svh"

module stq_checker
	import stq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic [STAT_W-1:0]    m_axis_tuser,
	input logic                 m_axis_tlast
);

	// stalled result stays put
	property p_out_hold;
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast);
	endproperty

	`STQ_ASSERT(a_out_hold, p_out_hold)

	// only expiries come in runs; every other status ends its request
	`STQ_ASSERT(a_single_last, m_axis_tvalid && m_axis_tuser != STAT_EXPIRED |-> m_axis_tlast)

	// id field is zero unless an expiry is reported
	`STQ_ASSERT(a_id_zero, m_axis_tvalid && m_axis_tuser != STAT_EXPIRED |-> m_axis_tdata[7:0] == 8'd0)

	// nonzero sleep only on a done status
	`STQ_ASSERT(a_sleep_done, m_axis_tvalid && m_axis_tdata[39:8] != 32'd0 |-> m_axis_tuser == STAT_DONE)

	// one request at a time: ready drops after a request is taken
	`STQ_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (.*);
